// ===== src/ps2kbd_pkg.sv =====
// Shared types, constants and scan code tables for the PS/2 set 2 key decoder.
`default_nettype none
package ps2kbd_pkg;

  localparam int unsigned KeyWidth = 7;

  localparam logic [7:0] PrefixBreak    = 8'hF0;
  localparam logic [7:0] PrefixExtended = 8'hE0;

  localparam logic [KeyWidth-1:0] KeyUnknown     = 7'd0;
  localparam logic [KeyWidth-1:0] KeyApplication = 7'd68;
  localparam logic [KeyWidth-1:0] KeyMax         = 7'd82;

  typedef struct packed {
    logic break_pending;
    logic extended_pending;
  } flags_t;

  typedef struct packed {
    logic                is_prefix;
    logic [KeyWidth-1:0] key;
    logic                down;
    flags_t              flags_next;
  } decode_t;

  function automatic logic [KeyWidth-1:0] normal_key(input logic [7:0] code);
    logic [KeyWidth-1:0] k;
    k = KeyUnknown;
    case (code)
      8'h76: k = 7'd1;
      8'h05: k = 7'd2;
      8'h06: k = 7'd3;
      8'h04: k = 7'd4;
      8'h0C: k = 7'd5;
      8'h03: k = 7'd6;
      8'h0B: k = 7'd7;
      8'h83: k = 7'd8;
      8'h0A: k = 7'd9;
      8'h01: k = 7'd10;
      8'h09: k = 7'd11;
      8'h78: k = 7'd12;
      8'h07: k = 7'd13;
      8'h0E: k = 7'd14;
      8'h16: k = 7'd15;
      8'h1E: k = 7'd16;
      8'h26: k = 7'd17;
      8'h25: k = 7'd18;
      8'h2E: k = 7'd19;
      8'h36: k = 7'd20;
      8'h3D: k = 7'd21;
      8'h3E: k = 7'd22;
      8'h46: k = 7'd23;
      8'h45: k = 7'd24;
      8'h4E: k = 7'd25;
      8'h55: k = 7'd26;
      8'h66: k = 7'd27;
      8'h0D: k = 7'd28;
      8'h15: k = 7'd29;
      8'h1D: k = 7'd30;
      8'h24: k = 7'd31;
      8'h2D: k = 7'd32;
      8'h2C: k = 7'd33;
      8'h35: k = 7'd34;
      8'h3C: k = 7'd35;
      8'h43: k = 7'd36;
      8'h44: k = 7'd37;
      8'h4D: k = 7'd38;
      8'h54: k = 7'd39;
      8'h5B: k = 7'd40;
      8'h5D: k = 7'd41;
      8'h58: k = 7'd42;
      8'h1C: k = 7'd43;
      8'h1B: k = 7'd44;
      8'h23: k = 7'd45;
      8'h2B: k = 7'd46;
      8'h34: k = 7'd47;
      8'h33: k = 7'd48;
      8'h3B: k = 7'd49;
      8'h42: k = 7'd50;
      8'h4B: k = 7'd51;
      8'h4C: k = 7'd52;
      8'h52: k = 7'd53;
      8'h5A: k = 7'd54;
      8'h12: k = 7'd55;
      8'h1A: k = 7'd56;
      8'h22: k = 7'd57;
      8'h21: k = 7'd58;
      8'h2A: k = 7'd59;
      8'h32: k = 7'd60;
      8'h31: k = 7'd61;
      8'h3A: k = 7'd62;
      8'h41: k = 7'd63;
      8'h49: k = 7'd64;
      8'h4A: k = 7'd65;
      8'h59: k = 7'd66;
      8'h14: k = 7'd67;
      8'h11: k = 7'd69;
      8'h29: k = 7'd70;
      default: k = KeyUnknown;
    endcase
    return k;
  endfunction

  function automatic logic [KeyWidth-1:0] extended_key(input logic [7:0] code);
    logic [KeyWidth-1:0] k;
    k = KeyUnknown;
    case (code)
      8'h11: k = 7'd71;
      8'h14: k = 7'd72;
      8'h75: k = 7'd73;
      8'h72: k = 7'd74;
      8'h6B: k = 7'd75;
      8'h74: k = 7'd76;
      8'h70: k = 7'd77;
      8'h71: k = 7'd78;
      8'h6C: k = 7'd79;
      8'h69: k = 7'd80;
      8'h7D: k = 7'd81;
      8'h7A: k = 7'd82;
      default: k = KeyUnknown;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== src/ps2kbd_decode.sv =====
// Byte classifier and key lookup for one registered scan code byte.
`default_nettype none
module ps2kbd_decode (
  input  wire logic [7:0]          scan_byte,
  input  wire ps2kbd_pkg::flags_t  flags,
  output ps2kbd_pkg::decode_t      dec
);
  import ps2kbd_pkg::*;

  logic is_break;
  logic is_extended;

  assign is_break    = (scan_byte == PrefixBreak);
  assign is_extended = (scan_byte == PrefixExtended);

  always_comb begin
    dec.is_prefix  = is_break || is_extended;
    dec.key        = flags.extended_pending ? extended_key(scan_byte) : normal_key(scan_byte);
    dec.down       = !flags.break_pending;
    dec.flags_next = '0;
    if (is_break) begin
      dec.flags_next = flags;
      dec.flags_next.break_pending = 1'b1;
    end else if (is_extended) begin
      dec.flags_next = flags;
      dec.flags_next.extended_pending = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/ps2_scan_code_set2_decoder.sv =====
// PS/2 scan code set 2 decoder top level.
// Input channel: one received keyboard byte per item on scan_byte, with
// in_valid and in_ready. Bytes 0xE0 and 0xF0 are prefixes: they set the
// extended and break flags and give no result item.
// Output channel: one item per non-prefix byte on key_number and key_down,
// with out_valid and out_ready. key_number 0 marks an unknown code.
// Path: an accepted byte is held in the input register, and its result is
// loaded into the output register once that register is free to take it.
// Throughput: one byte per cycle while no result is stalled, with the table
// lookup between the input register and the output register.
// Stall: while out_ready is low and a result is waiting, a further
// non-prefix byte stays in the input register and in_ready drops; prefix
// bytes still pass. Nothing is dropped or repeated.
// Reset: rst clears both prefix flags and both valid registers.
`default_nettype none
module ps2_scan_code_set2_decoder (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                in_valid,
  output logic                                      in_ready,
  input  wire  logic [7:0]                          scan_byte,
  output logic                                      out_valid,
  input  wire  logic                                out_ready,
  output logic [ps2kbd_pkg::KeyWidth-1:0]           key_number,
  output logic                                      key_down
);
  import ps2kbd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  flags_t     flags;
  decode_t    dec;
  logic       s1_advance;
  logic       out_free;
  logic       load_result;
  logic       out_valid_next;

  ps2kbd_decode u_decode (
    .scan_byte (s1_byte),
    .flags     (flags),
    .dec       (dec)
  );

  assign out_free    = !out_valid || out_ready;
  assign s1_advance  = s1_valid && (dec.is_prefix || out_free);
  assign load_result = s1_advance && !dec.is_prefix;
  assign in_ready    = !s1_valid || s1_advance;

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (load_result) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        flags <= dec.flags_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= scan_byte;
    end
    if (load_result) begin
      key_number <= dec.key;
      key_down   <= dec.down;
    end
  end

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_number <= KeyMax && key_number != KeyApplication))
    else $error("key number out of range");

  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (flags == '0))
    else $error("prefix flags not cleared after a result");

  a_break_set: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_byte == PrefixBreak) |=> flags.break_pending)
    else $error("break prefix not recorded");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_byte)))
    else $error("waiting byte lost from input register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(load_result))
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

// ===== tb/ps2_scan_code_set2_decoder_tb.sv =====
// Self-checking testbench for the PS/2 scan code set 2 key decoder.
`default_nettype none
module ps2_scan_code_set2_decoder_tb;
  import ps2kbd_pkg::*;

  typedef logic [KeyWidth-1:0] key_num_t;

  localparam int RandomBytes = 1800;
  localparam int CycleLimit  = 400000;

  // Make codes by key number; the application key has no code.
  localparam logic [7:0] PlainCodes [1:70] = '{
    8'h76, 8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01,
    8'h09, 8'h78, 8'h07, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36,
    8'h3D, 8'h3E, 8'h46, 8'h45, 8'h4E, 8'h55, 8'h66, 8'h0D, 8'h15, 8'h1D,
    8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D, 8'h54, 8'h5B,
    8'h5D, 8'h58, 8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42,
    8'h4B, 8'h4C, 8'h52, 8'h5A, 8'h12, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32,
    8'h31, 8'h3A, 8'h41, 8'h49, 8'h4A, 8'h59, 8'h14, 8'h00, 8'h11, 8'h29
  };

  localparam logic [7:0] ExtendedCodes [71:82] = '{
    8'h11, 8'h14, 8'h75, 8'h72, 8'h6B, 8'h74, 8'h70, 8'h71, 8'h6C, 8'h69,
    8'h7D, 8'h7A
  };

  localparam logic [7:0] DirectedBytes [26] = '{
    8'h76, 8'h05, 8'h83, 8'h29,
    PrefixExtended, 8'h11,
    PrefixExtended, 8'h14,
    PrefixExtended, PrefixBreak, 8'h7A,
    PrefixBreak, PrefixExtended, 8'h7A,
    PrefixBreak, 8'h76,
    8'h00, 8'hFF,
    PrefixExtended, 8'h76,
    PrefixBreak, PrefixExtended, PrefixBreak, 8'h14,
    8'h7F, 8'h80
  };

  class key_decode_board;
    typedef struct {
      key_num_t key;
      logic     down;
    } key_event_t;

    logic       break_seen;
    logic       extended_seen;
    key_num_t   plain_map [256];
    key_num_t   extended_map [256];
    key_event_t expected_keys [$];
    int         errors;

    function new();
      break_seen    = 1'b0;
      extended_seen = 1'b0;
      errors        = 0;
      foreach (plain_map[i]) begin
        plain_map[i]    = KeyUnknown;
        extended_map[i] = KeyUnknown;
      end
      for (int k = 1; k <= 70; k++) begin
        if (k != KeyApplication) plain_map[PlainCodes[k]] = key_num_t'(k);
      end
      for (int k = 71; k <= 82; k++) begin
        extended_map[ExtendedCodes[k]] = key_num_t'(k);
      end
    endfunction

    task report_error(input string what);
      if (errors < 50) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task note_byte(input logic [7:0] code);
      key_event_t ev;
      if (code == PrefixBreak) begin
        break_seen = 1'b1;
      end else if (code == PrefixExtended) begin
        extended_seen = 1'b1;
      end else begin
        ev.key  = extended_seen ? extended_map[code] : plain_map[code];
        ev.down = !break_seen;
        expected_keys.push_back(ev);
        break_seen    = 1'b0;
        extended_seen = 1'b0;
      end
    endtask

    task check_key(input key_num_t key, input logic down);
      key_event_t ev;
      if (expected_keys.size() == 0) begin
        report_error($sformatf("key %0d down %0b with nothing expected", key, down));
      end else begin
        ev = expected_keys.pop_front();
        if (key !== ev.key) begin
          report_error($sformatf("key_number %0d, expected %0d", key, ev.key));
        end
        if (down !== ev.down) begin
          report_error($sformatf("key_down %0b, expected %0b", down, ev.down));
        end
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] scan_byte;
  logic       out_valid;
  logic       out_ready;
  key_num_t   key_number;
  logic       key_down;

  key_decode_board sb;
  int              cycles;
  int              burst_left;
  int              bytes_sent;

  ps2_scan_code_set2_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scan_byte  (scan_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_number (key_number),
    .key_down   (key_down)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ps2_scan_code_set2_decoder_tb: FAIL");
      $finish;
    end
    if (!rst) begin
      if (out_valid && out_ready) sb.check_key(key_number, key_down);
      if (in_valid && in_ready) sb.note_byte(scan_byte);
    end
  end

  // Receiver: stall rate changes from phase to phase, and some phases never stall.
  initial begin
    int stall_pct;
    int phase_left;
    stall_pct  = 0;
    phase_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        phase_left = $urandom_range(50, 300);
      end
      phase_left--;
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle(gap);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    bytes_sent++;
    scan_byte <= code;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == PrefixBreak || b == PrefixExtended);
    return b;
  endfunction

  initial begin
    int         kind;
    int         k;
    logic       ext;
    logic [7:0] code;
    sb         = new();
    cycles     = 0;
    burst_left = 0;
    bytes_sent = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    scan_byte  = 8'h00;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);

    while (bytes_sent < RandomBytes) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        ext = ($urandom_range(9) < 4);
        if (ext) begin
          if ($urandom_range(99) < 85) code = ExtendedCodes[$urandom_range(71, 82)];
          else code = other_byte();
        end else if ($urandom_range(99) < 85) begin
          do k = $urandom_range(1, 70); while (k == KeyApplication);
          code = PlainCodes[k];
        end else begin
          code = other_byte();
        end
        if (ext) send_byte(PrefixExtended);
        if ($urandom_range(1) == 1) send_byte(PrefixBreak);
        send_byte(code);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(1) == 1) ? PrefixBreak : PrefixExtended);
        end
        send_byte(other_byte());
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ps2_scan_code_set2_decoder_tb: PASS");
    end else begin
      $display("ps2_scan_code_set2_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/ps2kbd_pkg.sv
src/ps2kbd_decode.sv
src/ps2_scan_code_set2_decoder.sv
tb/ps2_scan_code_set2_decoder_tb.sv
